/* hdl/priority_pushout_queue_manager_unit_defines.svh */
// assertion macros shared by the rtl
`ifndef PRIORITY_PUSHOUT_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define PRIORITY_PUSHOUT_QUEUE_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication
`define PPQM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPQM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ppqm_pkg.sv */
package ppqm_pkg;
    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 2048;
    localparam int QW          = $clog2(NUM_QUEUES);
    localparam int PW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = PW + 1;
    localparam int SLOTS       = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SW          = QW + PW;

    localparam logic [19:0] LIMIT_RESET = 20'd1000000;

    localparam logic [2:0] ST_ENQ     = 3'd0;
    localparam logic [2:0] ST_ENQ_EV  = 3'd1;
    localparam logic [2:0] ST_DROP    = 3'd2;
    localparam logic [2:0] ST_DEQ     = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [31:0] addr;
        logic [10:0] len;
        logic        prio;
    } t_entry;
endpackage

/* hdl/priority_pushout_queue_manager_unit.sv */
// enqueue that fits, drop, full, empty: result in the cycle after the transfer
// dequeue goes via S_DEQ; eviction: S_SCAN, S_CHK, compaction S_SH_RD/S_SH_WR, S_FIT
// one item at a time, busy high until the cycle its result is on the ports
// the walk goes through the packet memory (one read and one write port) one entry at a time
// reset (synchronous, active low) clears counts, bytes, heads and counters, limit to 1000000
// results are strobed on o_done for one cycle, the receiver cannot stall
`include "priority_pushout_queue_manager_unit_defines.svh"

module priority_pushout_queue_manager_unit
    import ppqm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [19:0] i_cfg_wr_data,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [1:0]  i_queue_id,
    input  logic [31:0] i_dest_addr,
    input  logic [10:0] i_pkt_len,
    input  logic        i_pkt_prio,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_addr,
    output logic [10:0] o_out_len,
    output logic        o_out_prio,
    output logic [11:0] o_evicted_now,
    output logic [11:0] o_occupancy,
    output logic [19:0] o_bytes_held,
    output logic [31:0] o_total_enqueued,
    output logic [31:0] o_total_dequeued,
    output logic [31:0] o_total_evicted
);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEQ   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHK   = 3'd3;
    localparam logic [2:0] S_SH_RD = 3'd4;
    localparam logic [2:0] S_SH_WR = 3'd5;
    localparam logic [2:0] S_FIT   = 3'd6;

    // packet store, one region per queue, circular inside the region
    t_entry      r_mem [SLOTS];
    t_entry      r_rdata;

    logic [2:0]  r_state;
    logic [19:0] r_limit;
    logic [CW-1:0] r_qcnt  [NUM_QUEUES];
    logic [19:0]   r_qbytes[NUM_QUEUES];
    logic [PW-1:0] r_head  [NUM_QUEUES];
    logic [31:0] r_enq_cnt, r_deq_cnt, r_ev_cnt;

    // working copy of the item in flight
    logic [QW-1:0] r_q;
    logic [31:0]   r_addr;
    logic [10:0]   r_len;
    logic [CW-1:0] r_j, r_k, r_cnt;
    logic [19:0]   r_bytes;
    logic [11:0]   r_evict;

    logic          mem_we;
    logic [SW-1:0] mem_wa, mem_ra;
    t_entry        mem_wd;
    logic [QW-1:0] q_sel;
    logic [PW-1:0] rd_log;
    logic [20:0]   in_sum, fit_sum;
    logic          in_fits, fit_ok;

    assign busy   = (r_state != S_IDLE);
    assign q_sel  = (r_state == S_IDLE) ? i_queue_id : r_q;

    // logical read position inside the queue
    always_comb begin
        case (r_state)
            S_SCAN:  rd_log = r_j[PW-1:0] - PW'(1);
            S_SH_RD: rd_log = r_k[PW-1:0] + PW'(1);
            default: rd_log = '0;
        endcase
    end
    assign mem_ra = {q_sel, r_head[q_sel] + rd_log};

    assign in_sum  = {1'b0, r_qbytes[i_queue_id]} + 21'(i_pkt_len);
    assign in_fits = in_sum < {1'b0, r_limit};
    assign fit_sum = {1'b0, r_bytes} + 21'(r_len);
    assign fit_ok  = fit_sum < {1'b0, r_limit};

    // single write port: append at idle, compaction move, append after eviction
    always_comb begin
        mem_we = 1'b0;
        mem_wa = {r_q, r_head[r_q] + r_k[PW-1:0]};
        mem_wd = r_rdata;
        case (r_state)
            S_IDLE: begin
                mem_we = start && !i_mode && (r_qcnt[i_queue_id] < CW'(QUEUE_DEPTH)) && in_fits;
                mem_wa = {i_queue_id, r_head[i_queue_id] + r_qcnt[i_queue_id][PW-1:0]};
                mem_wd = '{addr: i_dest_addr, len: i_pkt_len, prio: i_pkt_prio};
            end
            S_SH_WR: mem_we = 1'b1;
            S_FIT: begin
                mem_we = fit_ok;
                mem_wa = {r_q, r_head[r_q] + r_cnt[PW-1:0]};
                mem_wd = '{addr: r_addr, len: r_len, prio: 1'b1};
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= LIMIT_RESET;
            r_enq_cnt <= '0;
            r_deq_cnt <= '0;
            r_ev_cnt  <= '0;
            o_done    <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_qcnt[i]   <= '0;
                r_qbytes[i] <= '0;
                r_head[i]   <= '0;
            end
        end else begin
            o_done <= 1'b0;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_q        <= i_queue_id;
                        r_addr     <= i_dest_addr;
                        r_len      <= i_pkt_len;
                        r_cnt      <= r_qcnt[i_queue_id];
                        r_j        <= r_qcnt[i_queue_id];
                        r_bytes    <= r_qbytes[i_queue_id];
                        r_evict    <= '0;
                        o_out_addr <= '0;
                        o_out_len  <= '0;
                        o_out_prio <= 1'b0;
                        o_evicted_now    <= '0;
                        o_occupancy      <= 12'(r_qcnt[i_queue_id]);
                        o_bytes_held     <= r_qbytes[i_queue_id];
                        o_total_enqueued <= r_enq_cnt;
                        o_total_dequeued <= r_deq_cnt;
                        o_total_evicted  <= r_ev_cnt;
                        if (i_mode) begin
                            if (r_qcnt[i_queue_id] == '0) begin
                                o_status <= ST_EMPTY;
                                o_done   <= 1'b1;
                            end else begin
                                // head read issued this cycle
                                r_state <= S_DEQ;
                            end
                        end else if (r_qcnt[i_queue_id] >= CW'(QUEUE_DEPTH)) begin
                            o_status <= ST_FULL;
                            o_done   <= 1'b1;
                        end else if (in_fits) begin
                            r_qcnt[i_queue_id]   <= r_qcnt[i_queue_id] + CW'(1);
                            r_qbytes[i_queue_id] <= in_sum[19:0];
                            r_enq_cnt        <= r_enq_cnt + 32'd1;
                            o_total_enqueued <= r_enq_cnt + 32'd1;
                            o_occupancy      <= 12'(r_qcnt[i_queue_id] + CW'(1));
                            o_bytes_held     <= in_sum[19:0];
                            o_status <= ST_ENQ;
                            o_done   <= 1'b1;
                        end else if (!i_pkt_prio) begin
                            o_status <= ST_DROP;
                            o_done   <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_DEQ: begin
                    r_qcnt[r_q]   <= r_cnt - CW'(1);
                    r_qbytes[r_q] <= r_bytes - 20'(r_rdata.len);
                    r_head[r_q]   <= r_head[r_q] + PW'(1);
                    r_deq_cnt     <= r_deq_cnt + 32'd1;
                    o_total_dequeued <= r_deq_cnt + 32'd1;
                    o_occupancy   <= 12'(r_cnt - CW'(1));
                    o_bytes_held  <= r_bytes - 20'(r_rdata.len);
                    o_out_addr    <= r_rdata.addr;
                    o_out_len     <= r_rdata.len;
                    o_out_prio    <= r_rdata.prio;
                    o_status      <= ST_DEQ;
                    o_done        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_j == '0) begin
                        // never fit: dropped, evictions stand
                        r_qcnt[r_q]   <= r_cnt;
                        r_qbytes[r_q] <= r_bytes;
                        o_occupancy   <= 12'(r_cnt);
                        o_bytes_held  <= r_bytes;
                        o_evicted_now <= r_evict;
                        o_total_evicted <= r_ev_cnt;
                        o_status      <= ST_DROP;
                        o_done        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_j     <= r_j - CW'(1);
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (!r_rdata.prio) begin
                        r_bytes  <= r_bytes - 20'(r_rdata.len);
                        r_evict  <= r_evict + 12'd1;
                        r_ev_cnt <= r_ev_cnt + 32'd1;
                        r_k      <= r_j;
                        r_state  <= S_SH_RD;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SH_RD: begin
                    if ((r_k + CW'(1)) < r_cnt) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_FIT;
                    end
                end
                S_SH_WR: begin
                    // close the gap one entry at a time
                    r_k     <= r_k + CW'(1);
                    r_state <= S_SH_RD;
                end
                S_FIT: begin
                    if (fit_ok) begin
                        r_qcnt[r_q]   <= r_cnt + CW'(1);
                        r_qbytes[r_q] <= fit_sum[19:0];
                        r_enq_cnt     <= r_enq_cnt + 32'd1;
                        o_total_enqueued <= r_enq_cnt + 32'd1;
                        o_occupancy   <= 12'(r_cnt + CW'(1));
                        o_bytes_held  <= fit_sum[19:0];
                        o_evicted_now <= r_evict;
                        o_total_evicted <= r_ev_cnt;
                        o_status      <= ST_ENQ_EV;
                        o_done        <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PPQM_ASSERT_NEXT(a_start_progress, start && !busy, busy || o_done, "accepted item neither busy nor done")
    `PPQM_ASSERT_NOW(a_shift_in_range, r_state == S_SH_WR, (r_k + CW'(1)) < r_cnt, "compaction move beyond tail")
    `PPQM_ASSERT_NOW(a_occ_bound, o_done, o_occupancy <= 12'(QUEUE_DEPTH), "occupancy over depth")
    `PPQM_ASSERT_NOW(a_addr_zero, o_done && (o_status != ST_DEQ), o_out_addr == '0, "address without dequeue")

endmodule
